### sv/ptbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptbd_pkg
// Shared types and constants for the prime to binary-digits core.
// ----------------------------------------------------------------------------
package ptbd_pkg;

  localparam int ValueWidth       = 16;
  localparam int ResultWidth      = 48;
  localparam int DefaultValueBits = 16;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } req_t;

  typedef struct packed {
    logic signed [ResultWidth-1:0] result;
    logic                          is_prime;
    logic                          last_out;
  } rsp_t;

  // status from the remainder unit back to the sequencer
  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage
`default_nettype wire

### sv/prime_to_binary_digits_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prime_to_binary_digits_core
// Trial-division primality test; primes come out as their binary bits
// written as decimal digits, other values pass through sign-extended.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the block then stays
// busy until its single result has been shown. The result appears on rsp,
// marked by done for exactly one cycle, and the receiver cannot stall it.
// Values at or below one show their result in the cycle after the request,
// and the next request can be taken in the cycle after done. Otherwise each
// trial divisor is checked in the bit-serial remainder unit, and up to about
// sqrt(value) divisors are tried; a prime then goes through the digit
// conversion. The worst case is set by the remainder unit processing one bit
// a cycle.
// ----------------------------------------------------------------------------
module prime_to_binary_digits_core #(
  parameter int VALUE_BITS = ptbd_pkg::DefaultValueBits
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  ptbd_pkg::req_t      req,
  output logic                busy,
  output logic                done,
  output ptbd_pkg::rsp_t      rsp
);

  localparam int RW       = ptbd_pkg::ResultWidth;
  localparam int RawWidth = (VALUE_BITS > ptbd_pkg::ValueWidth) ? VALUE_BITS
                                                                 : ptbd_pkg::ValueWidth;
  localparam int DivBits  = VALUE_BITS / 2 + 2;
  localparam int SqBits   = VALUE_BITS + 2;
  localparam int CntWidth = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_CONV  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                   state;
  logic signed [VALUE_BITS-1:0] v;
  logic                         last_r;
  logic [VALUE_BITS-1:0]        n;
  logic [DivBits-1:0]           d;
  logic [SqBits-1:0]            sq;
  logic [RW-1:0]                acc;
  logic [RW-1:0]                acc_next;
  logic [CntWidth-1:0]          cnt;
  logic [RawWidth-1:0]          raw;
  logic signed [VALUE_BITS-1:0] in_v;
  logic [RW-1:0]                in_sext;
  logic [RW-1:0]                v_sext;
  logic                         rem_go;
  ptbd_pkg::rem_status_t        rem_st;
  ptbd_pkg::rsp_t               rsp_r;

  assign raw     = RawWidth'($unsigned(req.value));
  assign in_v    = raw[VALUE_BITS-1:0];
  assign in_sext = {{(RW-VALUE_BITS){in_v[VALUE_BITS-1]}}, in_v};
  assign v_sext  = {{(RW-VALUE_BITS){v[VALUE_BITS-1]}}, v};

  // next decimal digit: acc * 10 + bit
  assign acc_next = (acc << 3) + (acc << 1) + RW'(n[VALUE_BITS-1]);

  assign rem_go = (state == ST_CHECK) && (sq <= SqBits'(n));

  ptbd_rem #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DivBits)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .go       (rem_go),
    .dividend (n),
    .divisor  (d),
    .status   (rem_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= (in_v > $signed(VALUE_BITS'(1))) ? ST_CHECK : ST_DONE;
          end
        end
        ST_CHECK: begin
          state <= rem_go ? ST_DIV : ST_CONV;
        end
        ST_DIV: begin
          if (rem_st.done) begin
            state <= rem_st.zero ? ST_DONE : ST_CHECK;
          end
        end
        ST_CONV: begin
          if (cnt == CntWidth'(1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          v              <= in_v;
          last_r         <= req.last;
          n              <= in_v;
          d              <= DivBits'(2);
          sq             <= SqBits'(4);
          rsp_r.result   <= in_sext;
          rsp_r.is_prime <= 1'b0;
          rsp_r.last_out <= req.last;
        end
      end
      ST_CHECK: begin
        if (!rem_go) begin
          acc <= '0;
          cnt <= CntWidth'(VALUE_BITS);
        end
      end
      ST_DIV: begin
        if (rem_st.done && !rem_st.zero) begin
          // (d+1)^2 = d^2 + 2d + 1
          sq <= sq + SqBits'({d, 1'b1});
          d  <= d + 1'b1;
        end
      end
      ST_CONV: begin
        acc <= acc_next;
        n   <= {n[VALUE_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          rsp_r.result   <= acc_next;
          rsp_r.is_prime <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
  assign rsp  = rsp_r;

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done strobe longer than one cycle");

  a_request_makes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted but block not busy");

  a_rem_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_st.done |-> state == ST_DIV) else $error("remainder finished outside divide");

  a_passthrough_value: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.is_prime |-> rsp.result == v_sext)
    else $error("non-prime result differs from input");

  a_last_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> rsp.last_out == last_r) else $error("last marker not echoed");

endmodule
`default_nettype wire

### sv/ptbd_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptbd_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptbd_rem #(
  parameter int VALUE_BITS = ptbd_pkg::DefaultValueBits,
  parameter int DIV_BITS   = VALUE_BITS / 2 + 2
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     go,
  input  wire logic [VALUE_BITS-1:0]    dividend,
  input  wire logic [DIV_BITS-1:0]      divisor,
  output ptbd_pkg::rem_status_t         status
);

  localparam int CntWidth = $clog2(VALUE_BITS + 1);

  logic                  running;
  logic [CntWidth-1:0]   cnt;
  logic [VALUE_BITS-1:0] sh;
  logic [DIV_BITS-1:0]   dv;
  logic [DIV_BITS-1:0]   r;
  logic [DIV_BITS:0]     r_shift;
  logic [DIV_BITS-1:0]   r_next;
  logic                  done_r;
  logic                  zero_r;

  // partial remainder stays below the divisor, so the shifted value fits one more bit
  always_comb begin
    r_shift = {r, sh[VALUE_BITS-1]};
    if (r_shift >= {1'b0, dv}) begin
      r_next = DIV_BITS'(r_shift - {1'b0, dv});
    end else begin
      r_next = r_shift[DIV_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= CntWidth'(VALUE_BITS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          running <= 1'b0;
          done_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sh <= dividend;
      dv <= divisor;
      r  <= '0;
    end else if (running) begin
      sh     <= {sh[VALUE_BITS-2:0], 1'b0};
      r      <= r_next;
      zero_r <= (r_next == '0);
    end
  end

  assign status = '{done: done_r, zero: zero_r};

endmodule
`default_nettype wire
